// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: rtl/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

  localparam int SMP_W = 16;
  localparam int LVL_W = 17;
  localparam int PH_W  = 25;
  localparam int STG_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int MUL_AW    = 18;
  localparam int MUL_BW    = 26;
  localparam int MUL_STEPS = MUL_BW / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int PROD_W    = MUL_AW + 1 + MUL_BW;

  localparam logic [LVL_W-1:0] ONE_LEVEL = 17'd65536;
  localparam logic [PH_W-1:0]  ONE_PHASE = 25'h1000000;
  localparam logic [PH_W-1:0]  PHASE_MAX = 25'h1FFFFFF;

  localparam logic [LVL_W-1:0] SUSTAIN_RST = 17'd65536;
  localparam logic [LVL_W-1:0] POP_RST     = 17'd197;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POP     = 3'd4;

  typedef logic [STG_W-1:0] stage_t;
  localparam stage_t STG_ATTACK  = 3'd0;
  localparam stage_t STG_DECAY   = 3'd1;
  localparam stage_t STG_SUSTAIN = 3'd2;
  localparam stage_t STG_RELEASE = 3'd3;
  localparam stage_t STG_IDLE    = 3'd4;

  typedef enum logic [2:0] {
    TK_ATTACK,
    TK_DECAY,
    TK_SUSTAIN,
    TK_RELEASE,
    TK_ZERO
  } tgt_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_POP,
    S_LVL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_in;
    logic                    gate_held;
    logic                    note_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic [LVL_W-1:0]        level;
    logic [STG_W-1:0]        stage;
  } out_item_t;

  typedef struct packed {
    stage_t           stage;
    logic [PH_W-1:0]  phase;
    logic [PH_W-1:0]  phase_tgt;
    logic             gate_latched;
    tgt_kind_t        kind;
  } stage_res_t;

endpackage

// File: rtl/adsr_smul.sv
`timescale 1ns / 1ps

module adsr_smul import adsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [MUL_AW-1:0]    a_r;
  logic [MUL_BW-1:0]    b_r, b_nxt;
  logic [MUL_AW:0]      hi_r, hi_nxt;
  logic [MUL_BW-1:0]    lo_r, lo_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_AW+2:0]    a1, a2, sum;

  // radix-4 digit: two multiplier bits per cycle
  always_comb begin
    a1 = {{3{a_r[MUL_AW-1]}}, a_r};
    a2 = {a1[MUL_AW+1:0], 1'b0};
    sum = {{2{hi_r[MUL_AW]}}, hi_r}
          + (b_r[0] ? a1 : '0)
          + (b_r[1] ? a2 : '0);
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt   = '0;
      lo_nxt   = '0;
      b_nxt    = b;
      cnt_nxt  = MUL_CNT_W'(MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[MUL_AW+2:2];
      lo_nxt  = {sum[1:0], lo_r[MUL_BW-1:2]};
      b_nxt   = {2'b00, b_r[MUL_BW-1:2]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    b_r  <= b_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

// File: rtl/adsr_stage.sv
`timescale 1ns / 1ps

module adsr_stage import adsr_pkg::*; (
  input  stage_t           stage_r,
  input  logic [PH_W-1:0]  phase_r,
  input  logic             gate_latched_r,
  input  logic             gate_held,
  input  logic             note_start,
  input  logic [PH_W-1:0]  attack_step,
  input  logic [PH_W-1:0]  decay_step,
  input  logic [PH_W-1:0]  release_step,
  output stage_res_t       res
);

  stage_t          s;
  logic [PH_W-1:0] p;
  logic            g;
  logic [PH_W-1:0] step;
  logic [PH_W:0]   psum;
  logic [PH_W-1:0] psat;
  tgt_kind_t       kind;

  always_comb begin
    s = stage_r;
    p = phase_r;
    g = gate_latched_r;
    if (note_start) begin
      g = 1'b1;
      s = STG_ATTACK;
      p = '0;
    end
    if (g && !gate_held) begin
      if (s < STG_RELEASE) begin
        s = STG_RELEASE;
        p = '0;
      end
      g = 1'b0;
    end
    if (s > STG_IDLE) begin
      s = STG_IDLE;
    end
    if (s == STG_ATTACK && (attack_step == '0 || p >= ONE_PHASE)) begin
      s = STG_DECAY;
      p = '0;
    end
    if (s == STG_DECAY && decay_step == '0) begin
      s = STG_SUSTAIN;
      p = '0;
    end
    if (s == STG_RELEASE && (release_step == '0 || p >= ONE_PHASE)) begin
      s = STG_IDLE;
      p = '0;
    end

    unique case (s)
      STG_ATTACK: begin
        kind = TK_ATTACK;
        step = attack_step;
      end
      STG_DECAY: begin
        kind = TK_DECAY;
        step = decay_step;
      end
      STG_SUSTAIN: begin
        kind = TK_SUSTAIN;
        step = '0;
      end
      STG_RELEASE: begin
        kind = TK_RELEASE;
        step = release_step;
      end
      default: begin
        kind = TK_ZERO;
        step = '0;
      end
    endcase

    psum = {1'b0, p} + {1'b0, step};
    psat = psum[PH_W] ? PHASE_MAX : psum[PH_W-1:0];

    res.phase_tgt    = p;
    res.gate_latched = g;
    res.kind         = kind;
    res.stage        = s;
    res.phase        = p;
    if (kind == TK_ATTACK || kind == TK_DECAY || kind == TK_RELEASE) begin
      res.phase = psat;
    end
    if (kind == TK_DECAY && psat >= ONE_PHASE) begin
      res.stage = STG_SUSTAIN;
      res.phase = '0;
    end
  end

endmodule

// File: rtl/adsr_envelope_shaper.sv
`timescale 1ns / 1ps
// ADSR envelope shaper, one audio sample per input item.
// Input channel: in_valid/in_ready with in_item (sample, gate, note start).
// Result channel: out_valid/out_ready with out_item (shaped sample, level,
// stage after this sample); exactly one result item per input item.
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; always ready.
// Registers: 0 attack step, 1 decay step, 2 sustain, 3 release step, 4 pop
// limit. Write them only while no item is in flight.
// One item is worked on at a time. A single radix-4 serial multiplier,
// 13 steps per product, does the arithmetic: attack, sustain and idle items
// use it once; decay and release items use it twice.
// The finished result sits in an output register, so the next item is taken
// while it waits; a stalled receiver holds the block only when a second
// result is ready to be written.
// Reset (synchronous, rst_n low) loads the register defaults, sets the
// envelope to idle with level zero and drops out_valid.
module adsr_envelope_shaper import adsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  state_t            state_r, state_nxt;
  stage_t            stage_r, stage_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic              gate_r, gate_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  tgt_kind_t         kind_r, kind_nxt;
  logic [LVL_W-1:0]  tgt_r, tgt_nxt;
  logic [SMP_W-1:0]  sample_r, sample_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [PH_W-1:0]   attack_r, decay_r, release_r;
  logic [LVL_W-1:0]  sustain_r, pop_r;
  logic [LVL_W-1:0]  sus, sus_inv;

  stage_res_t        st_res;
  logic              mul_start, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic [19:0]       drop;
  logic [LVL_W:0]    lvl_up, lvl_dn;
  logic              accept;

  assign sus     = (sustain_r > ONE_LEVEL) ? ONE_LEVEL : sustain_r;
  assign sus_inv = ONE_LEVEL - sus;
  assign drop    = mul_prod[43:24];
  assign accept  = in_valid && in_ready;

  adsr_stage u_stage (
    .stage_r        (stage_r),
    .phase_r        (phase_r),
    .gate_latched_r (gate_r),
    .gate_held      (in_item.gate_held),
    .note_start     (in_item.note_start),
    .attack_step    (attack_r),
    .decay_step     (decay_r),
    .release_step   (release_r),
    .res            (st_res)
  );

  adsr_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    phase_nxt     = phase_r;
    gate_nxt      = gate_r;
    level_nxt     = level_r;
    kind_nxt      = kind_r;
    tgt_nxt       = tgt_r;
    sample_nxt    = sample_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    lvl_up        = {1'b0, level_r} + {1'b0, pop_r};
    lvl_dn        = {1'b0, level_r} - {1'b0, pop_r};
    in_ready      = (state_r == S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          stage_nxt  = st_res.stage;
          phase_nxt  = st_res.phase;
          gate_nxt   = st_res.gate_latched;
          kind_nxt   = st_res.kind;
          sample_nxt = in_item.sample_in;
          case (st_res.kind)
            TK_ATTACK:  tgt_nxt = {1'b0, st_res.phase_tgt[23:8]};
            TK_SUSTAIN: tgt_nxt = sus;
            default:    tgt_nxt = '0;
          endcase
          if (st_res.kind == TK_DECAY) begin
            mul_start = 1'b1;
            mul_a     = {1'b0, sus_inv};
            mul_b     = {1'b0, st_res.phase_tgt};
            state_nxt = S_TGT;
          end else if (st_res.kind == TK_RELEASE) begin
            mul_start = 1'b1;
            mul_a     = {1'b0, sus};
            mul_b     = {1'b0, ONE_PHASE - st_res.phase_tgt};
            state_nxt = S_TGT;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_TGT: begin
        if (mul_done) begin
          if (kind_r == TK_DECAY) begin
            tgt_nxt = (drop >= 20'(ONE_LEVEL)) ? '0 : LVL_W'(20'(ONE_LEVEL) - drop);
          end else begin
            tgt_nxt = mul_prod[40:24];
          end
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        level_nxt = tgt_r;
        if (tgt_r > level_r) begin
          if (tgt_r - level_r > pop_r) begin
            level_nxt = lvl_up[LVL_W-1:0];
          end
        end else if (level_r - tgt_r > pop_r) begin
          level_nxt = lvl_dn[LVL_W-1:0];
        end
        mul_start = 1'b1;
        mul_a     = {{(MUL_AW-SMP_W){sample_r[SMP_W-1]}}, sample_r};
        mul_b     = {{(MUL_BW-LVL_W){1'b0}}, level_nxt};
        state_nxt = S_LVL;
      end
      S_LVL: begin
        if (mul_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.sample_out = mul_prod[31:16];
          out_item_nxt.level      = level_r;
          out_item_nxt.stage      = stage_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= STG_IDLE;
      phase_r     <= '0;
      gate_r      <= 1'b0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      phase_r     <= phase_nxt;
      gate_r      <= gate_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    tgt_r      <= tgt_nxt;
    sample_r   <= sample_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      sustain_r <= SUSTAIN_RST;
      release_r <= '0;
      pop_r     <= POP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_r  <= cfg_data;
        CFG_DECAY:   decay_r   <= cfg_data;
        CFG_SUSTAIN: sustain_r <= cfg_data[LVL_W-1:0];
        CFG_RELEASE: release_r <= cfg_data;
        CFG_POP:     pop_r     <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |=> !out_valid_r, "out_valid after reset")
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, accept |=> !in_ready, "accept while busy")
  `ASSERT_CLK(a_mul_done_state, clk, rst_n,
    mul_done |-> (state_r == S_TGT || state_r == S_LVL), "stray multiply done")
  `ASSERT_CLK(a_level_range, clk, rst_n,
    out_valid_r |-> (out_item_r.level <= ONE_LEVEL), "level above full scale")

endmodule

// File: dv/envelope_checker.sv
`timescale 1ns / 1ps

module envelope_checker import adsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    in_flight
);

  logic [PH_W-1:0]  attack_reg, decay_reg, release_reg;
  logic [LVL_W-1:0] sustain_reg, pop_reg;

  stage_t           env_stage;
  logic [PH_W-1:0]  env_phase;
  logic [LVL_W-1:0] env_level;
  logic             gate_armed;

  out_item_t shaped_q[$];
  out_item_t want;

  initial mismatches = 0;
  initial in_flight = 0;

  function automatic logic [PH_W-1:0] phase_add(input logic [PH_W-1:0] p,
                                                input logic [PH_W-1:0] s);
    logic [PH_W:0] sum;
    sum = {1'b0, p} + {1'b0, s};
    return (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[PH_W-1:0];
  endfunction

  function automatic out_item_t shape_sample(input in_item_t it);
    logic [LVL_W-1:0] sus;
    logic [LVL_W-1:0] tgt;
    logic [41:0]      prod;
    logic [17:0]      drop;
    logic             settled;
    longint           scaled;
    out_item_t        res;
    sus = (sustain_reg > ONE_LEVEL) ? ONE_LEVEL : sustain_reg;
    tgt = '0;
    settled = 1'b0;
    if (it.note_start) begin
      gate_armed = 1'b1;
      env_stage = STG_ATTACK;
      env_phase = '0;
    end
    if (gate_armed && !it.gate_held) begin
      if (env_stage < STG_RELEASE) begin
        env_stage = STG_RELEASE;
        env_phase = '0;
      end
      gate_armed = 1'b0;
    end
    if (env_stage > STG_IDLE) env_stage = STG_IDLE;

    if (env_stage == STG_ATTACK) begin
      if (attack_reg != 0 && env_phase < ONE_PHASE) begin
        tgt = LVL_W'(env_phase >> 8);
        env_phase = phase_add(env_phase, attack_reg);
        settled = 1'b1;
      end else begin
        env_phase = '0;
        env_stage = STG_DECAY;
      end
    end
    if (!settled && env_stage == STG_DECAY) begin
      if (decay_reg != 0) begin
        prod = 42'(env_phase) * 42'(ONE_LEVEL - sus);
        drop = 18'(prod >> 24);
        tgt = (drop >= 18'd65536) ? '0 : LVL_W'(18'd65536 - drop);
        env_phase = phase_add(env_phase, decay_reg);
        if (env_phase >= ONE_PHASE) begin
          env_stage = STG_SUSTAIN;
          env_phase = '0;
        end
        settled = 1'b1;
      end else begin
        env_phase = '0;
        env_stage = STG_SUSTAIN;
      end
    end
    if (!settled && env_stage == STG_SUSTAIN) begin
      tgt = sus;
      settled = 1'b1;
    end
    if (!settled && env_stage == STG_RELEASE) begin
      if (release_reg != 0 && env_phase < ONE_PHASE) begin
        prod = 42'(sus) * 42'(ONE_PHASE - env_phase);
        tgt = LVL_W'(prod >> 24);
        env_phase = phase_add(env_phase, release_reg);
        settled = 1'b1;
      end else begin
        env_phase = '0;
        env_stage = STG_IDLE;
      end
    end
    if (!settled) tgt = '0;

    // slew limit toward the target
    if (tgt > env_level) begin
      if (tgt - env_level > pop_reg) tgt = env_level + pop_reg;
    end else if (env_level - tgt > pop_reg) begin
      tgt = env_level - pop_reg;
    end
    env_level = tgt;

    scaled = (longint'($signed(it.sample_in)) * longint'(env_level)) >>> 16;
    res.sample_out = scaled[SMP_W-1:0];
    res.level = env_level;
    res.stage = env_stage;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      attack_reg = '0;
      decay_reg = '0;
      sustain_reg = SUSTAIN_RST;
      release_reg = '0;
      pop_reg = POP_RST;
      env_stage = STG_IDLE;
      env_phase = '0;
      env_level = '0;
      gate_armed = 1'b0;
      shaped_q.delete();
      in_flight <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATTACK:  attack_reg = cfg_data;
          CFG_DECAY:   decay_reg = cfg_data;
          CFG_SUSTAIN: sustain_reg = cfg_data[LVL_W-1:0];
          CFG_RELEASE: release_reg = cfg_data;
          CFG_POP:     pop_reg = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (shaped_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got %0d/%0d/%0d", $time,
                   out_item.sample_out, out_item.level, out_item.stage);
          mismatches++;
        end else begin
          want = shaped_q.pop_front();
          if (out_item.sample_out !== want.sample_out) begin
            $display("%0t: sample_out expected %0d got %0d", $time,
                     want.sample_out, out_item.sample_out);
            mismatches++;
          end
          if (out_item.level !== want.level) begin
            $display("%0t: level expected %0d got %0d", $time, want.level, out_item.level);
            mismatches++;
          end
          if (out_item.stage !== want.stage) begin
            $display("%0t: stage expected %0d got %0d", $time, want.stage, out_item.stage);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) shaped_q.push_back(shape_sample(in_item));
      in_flight <= shaped_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import adsr_pkg::*;

  localparam int LIMIT = 500000;
  localparam int PHASE_ITEMS = 180;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int in_flight;
  int cycle_cnt = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  bit held_once = 1'b0;

  always #5 clk = ~clk;

  adsr_envelope_shaper uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  envelope_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_setting(input logic [CFG_IDX_W-1:0] idx);
    int pick;
    pick = $urandom_range(0, 11);
    if (idx == CFG_SUSTAIN) begin
      case (pick)
        0: return '0;
        1: return CFG_DATA_W'(ONE_LEVEL);
        2: return CFG_DATA_W'($urandom);
        default: return CFG_DATA_W'($urandom_range(0, 65536));
      endcase
    end else if (idx == CFG_POP) begin
      case (pick)
        0: return '0;
        1: return CFG_DATA_W'(POP_RST);
        2: return CFG_DATA_W'(ONE_LEVEL);
        3: return CFG_DATA_W'($urandom_range(65537, 25'h1ffffff));
        default: return CFG_DATA_W'($urandom_range(1, 8192));
      endcase
    end else begin
      case (pick)
        0: return '0;
        1: return ONE_PHASE;
        2: return CFG_DATA_W'($urandom_range(25'h1000000, 25'h1ffffff));
        3: return CFG_DATA_W'($urandom_range(1, 1 << 16));
        default: return CFG_DATA_W'($urandom_range(1 << 19, 1 << 24));
      endcase
    end
  endfunction

  task automatic push_sample(input logic [SMP_W-1:0] smp, input logic gate,
                             input logic start);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{sample_in: smp, gate_held: gate, note_start: start};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] atk, dcy, sus, rel, pop);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0]  idxs[5];
    vals = '{atk, dcy, sus, rel, pop};
    idxs = '{CFG_ATTACK, CFG_DECAY, CFG_SUSTAIN, CFG_RELEASE, CFG_POP};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (in_flight != 0);
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off && !held_once) begin
        out_ready <= 1'b0;
        held_once = 1'b1;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stim
    int n, held, rel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: attack and decay skipped straight to sustain, release straight to idle, slow slew
    push_sample(16'h7fff, 1'b1, 1'b1);
    push_sample(16'h8000, 1'b1, 1'b0);
    push_sample(16'h7fff, 1'b1, 1'b0);
    push_sample(16'hffff, 1'b0, 1'b0);
    push_sample(16'h7fff, 1'b0, 1'b0);
    in_valid <= 1'b0;
    settle();

    // four samples per attack, decay and release stage, no slew limit
    load_regs(CFG_DATA_W'(1 << 22), CFG_DATA_W'(1 << 22), CFG_DATA_W'(32768),
              CFG_DATA_W'(1 << 22), CFG_DATA_W'(ONE_LEVEL));
    push_sample(16'h7fff, 1'b1, 1'b1);
    push_sample(16'h8000, 1'b1, 1'b0);
    push_sample(16'hffff, 1'b1, 1'b0);
    push_sample(16'h0001, 1'b1, 1'b0);
    push_sample(16'h7fff, 1'b1, 1'b0);
    push_sample(16'h8000, 1'b1, 1'b0);
    push_sample(16'h7fff, 1'b1, 1'b0);
    push_sample(16'h8000, 1'b1, 1'b0);
    push_sample(16'h7fff, 1'b1, 1'b0);
    push_sample(16'h0000, 1'b0, 1'b0);
    push_sample(16'h7fff, 1'b0, 1'b0);
    push_sample(16'h8000, 1'b0, 1'b0);
    push_sample(16'h7fff, 1'b0, 1'b0);
    push_sample(16'h8000, 1'b0, 1'b0);
    push_sample(16'h7fff, 1'b0, 1'b0);
    // start with the gate already low goes straight to release
    push_sample(16'h7fff, 1'b0, 1'b1);
    // a rising gate alone does not arm the envelope
    push_sample(16'h8000, 1'b1, 1'b0);
    push_sample(16'h7fff, 1'b1, 1'b1);
    push_sample(16'h8000, 1'b1, 1'b1);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: load_regs(ONE_PHASE, ONE_PHASE, CFG_DATA_W'(ONE_LEVEL), ONE_PHASE,
                     CFG_DATA_W'(ONE_LEVEL));
        1: load_regs('0, '0, '0, '0, '0);
        2: load_regs('1, '1, '1, '1, '1);
        default: load_regs(rand_setting(CFG_ATTACK), rand_setting(CFG_DECAY),
                           rand_setting(CFG_SUSTAIN), rand_setting(CFG_RELEASE),
                           rand_setting(CFG_POP));
      endcase
      if (ph == 3) hold_off <= 1'b1;
      if (ph == 7) quiet <= 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          push_sample(rand_sample(), 1'($urandom), $urandom_range(0, 3) == 0);
          n++;
        end else begin
          held = $urandom_range(1, 40);
          rel = $urandom_range(0, 30);
          for (int i = 0; i < held; i++) push_sample(rand_sample(), 1'b1, i == 0);
          for (int i = 0; i < rel; i++) push_sample(rand_sample(), 1'b0, 1'b0);
          n += held + rel;
        end
      end
      in_valid <= 1'b0;
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_smul.sv
rtl/adsr_stage.sv
rtl/adsr_envelope_shaper.sv
dv/envelope_checker.sv
dv/tb_top.sv
